// ===== hw/rtl/qte_pkg.sv =====
package qte_pkg;

  // pipeline geometry
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_ROT       = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int SQRT_STEPS    = 32;
  localparam int NUM_STAGES    = 4 + SQRT_STEPS + NUM_ROT;

  // datapath widths
  localparam int VEC_W = 36;
  localparam int ANG_W = 34;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  localparam vec_t ONE_Q30     = 36'sd1073741824;
  localparam ang_t HALF_PI_Q30 = 34'sd1686629713;
  localparam vec_t ROLL_LIMIT  = 36'sd25736;
  localparam vec_t PITCH_LIMIT = 36'sd12868;
  localparam vec_t ROUND_HALF  = 36'sd65536;

  // atan(2^-i) in Q.30 radians
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128
  };

  typedef struct packed {
    logic signed [31:0] wx;
    logic signed [31:0] yz;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] wz;
    logic signed [31:0] xy;
    logic signed [31:0] zz;
    logic signed [31:0] wy;
    logic signed [31:0] xz;
  } prod_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_t;

  typedef struct packed {
    vec_t  sr;
    vec_t  cr;
    vec_t  sy;
    vec_t  cy;
    sqrt_t sp;
    sqrt_t cp;
  } front_t;

  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
    logic zero;
  } rot_t;

  typedef struct packed {
    rot_t roll;
    rot_t pitch;
    rot_t yaw;
  } rot3_t;

  // one digit of the floor square root
  function automatic sqrt_t sqrt_step(input sqrt_t s, input int i);
    logic [63:0] bitv;
    logic [63:0] trial;
    sqrt_t r;
    bitv  = 64'd1 << (62 - 2 * i);
    trial = s.root + bitv;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  // fold the left half plane into the right one
  function automatic rot_t prerotate(input vec_t y, input vec_t x);
    rot_t r;
    r.zero = (x == '0) && (y == '0);
    r.x    = x;
    r.y    = y;
    r.z    = '0;
    if (x < 0) begin
      if (y >= 0) begin
        r.x = y;
        r.y = -x;
        r.z = HALF_PI_Q30;
      end else begin
        r.x = -y;
        r.y = x;
        r.z = -HALF_PI_Q30;
      end
    end
    return r;
  endfunction

  // one vectoring micro-rotation
  function automatic rot_t cordic_step(input rot_t r, input int i);
    vec_t xs;
    vec_t ys;
    ang_t da;
    rot_t o;
    xs     = r.x >>> i;
    ys     = r.y >>> i;
    da     = ang_t'(ATAN_Q30[i]);
    o.zero = r.zero;
    if (r.y >= 0) begin
      o.x = r.x + ys;
      o.y = r.y - xs;
      o.z = r.z + da;
    end else begin
      o.x = r.x - ys;
      o.y = r.y + xs;
      o.z = r.z - da;
    end
    return o;
  endfunction

  // Q.30 to Q2.13 with rounding and clamp
  function automatic logic signed [15:0] round_angle(input vec_t a, input vec_t limit);
    vec_t t;
    t = (a + ROUND_HALF) >>> 17;
    if (t > limit) t = limit;
    if (t < -limit) t = -limit;
    return t[15:0];
  endfunction

endpackage

// ===== hw/rtl/qte_if.sv =====
// quaternion input channel
interface qte_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// euler angle output channel
interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll;
  logic signed [14:0] pitch;
  logic signed [15:0] yaw;
  modport source (output valid, roll, pitch, yaw, input ready);
  modport sink (input valid, roll, pitch, yaw, output ready);
endinterface

// ===== hw/rtl/quat_to_euler_angles_top.sv =====
// throughput: one item per cycle while euler_out.ready holds;
// each stage holds one item and moves when the next is free
// depth: product, front, 32 square-root digit, fold, unrolled cordic and output stages
// reset: synchronous, clears all stage valid bits; data registers are not reset
module quat_to_euler_angles_top import qte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qte_quat_if.sink    quat_in,
  qte_euler_if.source euler_out
);

  localparam int ST_B    = 1;
  localparam int ST_SQ   = 2;
  localparam int ST_PRE  = ST_SQ + SQRT_STEPS;
  localparam int ST_ROT  = ST_PRE + 1;
  localparam int ST_OUT  = ST_ROT + NUM_ROT;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  prod_t  prod;
  front_t front;
  front_t sq [SQRT_STEPS];
  rot3_t  pre;
  rot3_t  rot [NUM_ROT];

  logic signed [15:0] roll_q;
  logic signed [14:0] pitch_q;
  logic signed [15:0] yaw_q;

  // stall chain: a stage moves when empty or when its successor moves
  assign en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || euler_out.ready;
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign quat_in.ready = en[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= quat_in.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod.wx <= 32'(quat_in.quat_w) * 32'(quat_in.quat_x);
      prod.yz <= 32'(quat_in.quat_y) * 32'(quat_in.quat_z);
      prod.xx <= 32'(quat_in.quat_x) * 32'(quat_in.quat_x);
      prod.yy <= 32'(quat_in.quat_y) * 32'(quat_in.quat_y);
      prod.wz <= 32'(quat_in.quat_w) * 32'(quat_in.quat_z);
      prod.xy <= 32'(quat_in.quat_x) * 32'(quat_in.quat_y);
      prod.zz <= 32'(quat_in.quat_z) * 32'(quat_in.quat_z);
      prod.wy <= 32'(quat_in.quat_w) * 32'(quat_in.quat_y);
      prod.xz <= 32'(quat_in.quat_x) * 32'(quat_in.quat_z);
    end
  end

  // sine and cosine terms, square-root arguments
  vec_t a1;
  vec_t a2;
  vec_t s2;
  front_t front_next;

  always_comb begin
    s2 = (VEC_W'(prod.wy) - VEC_W'(prod.xz)) <<< 1;
    a1 = ONE_Q30 + s2;
    a2 = ONE_Q30 - s2;
    front_next.sr = (VEC_W'(prod.wx) + VEC_W'(prod.yz)) <<< 1;
    front_next.cr = ONE_Q30 - ((VEC_W'(prod.xx) + VEC_W'(prod.yy)) <<< 1);
    front_next.sy = (VEC_W'(prod.wz) + VEC_W'(prod.xy)) <<< 1;
    front_next.cy = ONE_Q30 - ((VEC_W'(prod.yy) + VEC_W'(prod.zz)) <<< 1);
    front_next.sp.rem  = (a1 < 0) ? '0 : {31'd0, a1[32:0]} << 30;
    front_next.sp.root = '0;
    front_next.cp.rem  = (a2 < 0) ? '0 : {31'd0, a2[32:0]} << 30;
    front_next.cp.root = '0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_B]) front <= front_next;
  end

  // square root, one digit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    front_t src;
    if (k == 0) begin : g_first
      assign src = front;
    end else begin : g_rest
      assign src = sq[k-1];
    end
    always_ff @(posedge clk) begin
      if (en[ST_SQ+k]) begin
        sq[k].sr <= src.sr;
        sq[k].cr <= src.cr;
        sq[k].sy <= src.sy;
        sq[k].cy <= src.cy;
        sq[k].sp <= sqrt_step(src.sp, k);
        sq[k].cp <= sqrt_step(src.cp, k);
      end
    end
  end

  // quadrant fold
  always_ff @(posedge clk) begin
    if (en[ST_PRE]) begin
      pre.roll  <= prerotate(sq[SQRT_STEPS-1].sr, sq[SQRT_STEPS-1].cr);
      pre.yaw   <= prerotate(sq[SQRT_STEPS-1].sy, sq[SQRT_STEPS-1].cy);
      pre.pitch <= prerotate(vec_t'({4'd0, sq[SQRT_STEPS-1].sp.root[31:0]}),
                             vec_t'({4'd0, sq[SQRT_STEPS-1].cp.root[31:0]}));
    end
  end

  // cordic micro-rotations, three vectors side by side
  for (genvar k = 0; k < NUM_ROT; k++) begin : g_rot
    rot3_t src;
    if (k == 0) begin : g_first
      assign src = pre;
    end else begin : g_rest
      assign src = rot[k-1];
    end
    always_ff @(posedge clk) begin
      if (en[ST_ROT+k]) begin
        rot[k].roll  <= cordic_step(src.roll, k);
        rot[k].pitch <= cordic_step(src.pitch, k);
        rot[k].yaw   <= cordic_step(src.yaw, k);
      end
    end
  end

  // final angles
  ang_t  z_roll;
  ang_t  z_pitch;
  ang_t  z_yaw;
  vec_t  pitch_full;
  logic signed [15:0] pitch_r;

  always_comb begin
    z_roll     = rot[NUM_ROT-1].roll.zero  ? '0 : rot[NUM_ROT-1].roll.z;
    z_pitch    = rot[NUM_ROT-1].pitch.zero ? '0 : rot[NUM_ROT-1].pitch.z;
    z_yaw      = rot[NUM_ROT-1].yaw.zero   ? '0 : rot[NUM_ROT-1].yaw.z;
    pitch_full = (VEC_W'(z_pitch) <<< 1) - VEC_W'(HALF_PI_Q30);
    pitch_r    = round_angle(pitch_full, PITCH_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      roll_q  <= round_angle(VEC_W'(z_roll), ROLL_LIMIT);
      pitch_q <= pitch_r[14:0];
      yaw_q   <= round_angle(VEC_W'(z_yaw), ROLL_LIMIT);
    end
  end

  assign euler_out.valid = vld[ST_OUT];
  assign euler_out.roll  = roll_q;
  assign euler_out.pitch = pitch_q;
  assign euler_out.yaw   = yaw_q;

endmodule
